// File: rtl/core/fmon_pkg.sv
// fmon_pkg: shared types and constants of the frame time monitor.
// Holds the beat structs, controller state codes and the controller/datapath
// command and status structs. Depends on nothing.
package fmon_pkg;

  localparam int HISTORY_DEPTH_DEF = 128;
  localparam int BUDGET_W          = 20;
  localparam int TIME_W            = 24;
  localparam int CNT_W             = 32;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 20'd16667;
  localparam logic [CNT_W-1:0]    CNT_MAX      = 32'hFFFF_FFFF;
  localparam int PCT_NUM = 95;
  localparam int PCT_DEN = 100;

  typedef struct packed {
    logic              action;
    logic [TIME_W-1:0] frame_time_us;
  } in_beat_t;

  typedef struct packed {
    logic              janked;
    logic              dropped_flag;
    logic [TIME_W-1:0] dropped_now;
    logic [CNT_W-1:0]  frames_total;
    logic [CNT_W-1:0]  jank_total;
    logic [CNT_W-1:0]  dropped_total;
    logic [TIME_W-1:0] mean_us;
    logic [TIME_W-1:0] p95_us;
  } out_beat_t;

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_CLEAR    = 11'b000_0000_0010,
    ST_READ_OLD = 11'b000_0000_0100,
    ST_UPDATE   = 11'b000_0000_1000,
    ST_DIV_DROP = 11'b000_0001_0000,
    ST_DIV_MEAN = 11'b000_0010_0000,
    ST_OUTER    = 11'b000_0100_0000,
    ST_LATCH    = 11'b000_1000_0000,
    ST_INNER    = 11'b001_0000_0000,
    ST_CHECK    = 11'b010_0000_0000,
    ST_DONE     = 11'b100_0000_0000
  } state_t;

  typedef enum logic {
    DIV_DROP = 1'b0,
    DIV_MEAN = 1'b1
  } div_sel_t;

  typedef struct packed {
    logic     accept;
    logic     clear;
    logic     rd_old;
    logic     update;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_drop;
    logic     cap_mean;
    logic     cap_rank;
    logic     outer_rd;
    logic     outer_cap;
    logic     inner_step;
    logic     cap_p95;
    logic     check_next;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic inner_done;
    logic found;
    logic outer_last;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/core/fmon_div.sv
// fmon_div: restoring divider, one quotient bit per cycle.
// Used by the datapath for the drop count and the window mean.
module fmon_div #(
  parameter int DVD_W = 32,
  parameter int DVS_W = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  quo;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    diff;
  logic              qbit;

  always_comb begin
    shifted = {rem, quo[DVD_W-1]};
    diff    = shifted - {1'b0, dvs};
    qbit    = (shifted >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], qbit};
      rem <= qbit ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

// File: rtl/core/fmon_ctrl.sv
// fmon_ctrl: sequencing state machine of the frame time monitor.
// Uses fmon_pkg for state codes and the command and status structs.
module fmon_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_action,
  input  fmon_pkg::dp_stat_t   stat,
  output fmon_pkg::ctrl_cmd_t  cmd,
  output logic                 in_stall
);

  fmon_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fmon_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = fmon_pkg::DIV_DROP;
    state_next  = state;
    unique case (state)
      fmon_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = in_action ? fmon_pkg::ST_CLEAR : fmon_pkg::ST_READ_OLD;
        end
      end
      fmon_pkg::ST_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = fmon_pkg::ST_DONE;
      end
      fmon_pkg::ST_READ_OLD: begin
        cmd.rd_old = 1'b1;
        state_next = fmon_pkg::ST_UPDATE;
      end
      fmon_pkg::ST_UPDATE: begin
        cmd.update    = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel   = fmon_pkg::DIV_DROP;
        state_next    = fmon_pkg::ST_DIV_DROP;
      end
      fmon_pkg::ST_DIV_DROP: begin
        if (stat.div_done) begin
          cmd.cap_drop  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = fmon_pkg::DIV_MEAN;
          state_next    = fmon_pkg::ST_DIV_MEAN;
        end
      end
      fmon_pkg::ST_DIV_MEAN: begin
        if (stat.div_done) begin
          cmd.cap_mean = 1'b1;
          cmd.cap_rank = 1'b1;
          state_next   = fmon_pkg::ST_OUTER;
        end
      end
      fmon_pkg::ST_OUTER: begin
        cmd.outer_rd = 1'b1;
        state_next   = fmon_pkg::ST_LATCH;
      end
      fmon_pkg::ST_LATCH: begin
        cmd.outer_cap = 1'b1;
        state_next    = fmon_pkg::ST_INNER;
      end
      fmon_pkg::ST_INNER: begin
        cmd.inner_step = 1'b1;
        if (stat.inner_done) begin
          state_next = fmon_pkg::ST_CHECK;
        end
      end
      fmon_pkg::ST_CHECK: begin
        if (stat.found) begin
          cmd.cap_p95 = 1'b1;
          state_next  = fmon_pkg::ST_DONE;
        end else if (stat.outer_last) begin
          state_next = fmon_pkg::ST_DONE;
        end else begin
          cmd.check_next = 1'b1;
          state_next     = fmon_pkg::ST_OUTER;
        end
      end
      fmon_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = fmon_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fmon_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state != fmon_pkg::ST_IDLE);

endmodule

// File: rtl/core/fmon_dp.sv
// fmon_dp: datapath of the frame time monitor: budget register, counters,
// window memory, shared divider, rank counting and output register.
// Depends on fmon_pkg and fmon_div.
module fmon_dp #(
  parameter int HISTORY_DEPTH = fmon_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fmon_pkg::BUDGET_W-1:0] cfg_wdata,
  input  fmon_pkg::in_beat_t            in_data,
  input  logic                          out_stall,
  input  fmon_pkg::ctrl_cmd_t           cmd,
  output fmon_pkg::dp_stat_t            stat,
  output logic                          out_valid,
  output fmon_pkg::out_beat_t           out_data
);

  localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int TW     = fmon_pkg::TIME_W;
  localparam int BW     = fmon_pkg::BUDGET_W;
  localparam int CW     = fmon_pkg::CNT_W;
  localparam int SUM_W  = TW + FILL_W;
  // The percentile rank floor(fill*95/100) is a reciprocal multiply; with a
  // 24-bit shift it is exact for every window fill up to 2000.
  localparam int RANK_SHIFT = 24;
  localparam int RANK_MUL   = ((1 << RANK_SHIFT) + fmon_pkg::PCT_DEN - 1) /
                              fmon_pkg::PCT_DEN * fmon_pkg::PCT_NUM;
  localparam int PROD_W     = FILL_W + RANK_SHIFT;

  logic [BW-1:0]     budget;
  logic [BW-1:0]     b_eff;
  logic [TW-1:0]     t;
  logic [PTR_W-1:0]  ptr;
  logic [FILL_W-1:0] fill;
  logic [SUM_W-1:0]  sum;
  logic [CW-1:0]     frames, janks, drops;
  logic              res_jank, res_drop;
  logic [TW-1:0]     res_drop_now, res_mean, res_p95;
  logic [FILL_W-1:0] k, i, j, less, lesseq;
  logic [TW-1:0]     v;
  logic              pend;
  logic [TW-1:0]     mem [HISTORY_DEPTH];
  logic [TW-1:0]     rd_data;
  logic [PTR_W-1:0]  rd_addr;
  logic              is_jank, is_drop;
  logic              full;
  logic [SUM_W-1:0]  dvd;
  logic [BW-1:0]     dvs;
  logic              div_done;
  logic [SUM_W-1:0]  quo;
  logic [PROD_W-1:0] rank_prod;
  logic [FILL_W-1:0] rank_q;
  logic [TW-1:0]     drop_q;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                            input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? fmon_pkg::CNT_MAX : s[CW-1:0];
  endfunction

  assign b_eff   = (budget == '0) ? BW'(1) : budget;
  assign is_jank = ({{(TW - BW){1'b0}}, b_eff} < t);
  assign is_drop = ({{(TW - BW - 1){1'b0}}, b_eff, 1'b0} < t);
  assign full    = (fill == FILL_W'(HISTORY_DEPTH));

  // Divider operand selection.
  always_comb begin
    unique case (cmd.div_sel)
      fmon_pkg::DIV_DROP: begin
        dvd = SUM_W'(t);
        dvs = b_eff;
      end
      fmon_pkg::DIV_MEAN: begin
        dvd = sum;
        dvs = BW'(fill);
      end
    endcase
  end

  fmon_div #(.DVD_W(SUM_W), .DVS_W(BW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  assign rank_prod = PROD_W'(fill) * PROD_W'(RANK_MUL);
  assign rank_q    = rank_prod[PROD_W-1:RANK_SHIFT];
  assign drop_q    = quo[TW-1:0];

  // Window memory: one write port, one registered read port.
  always_comb begin
    priority if (cmd.rd_old) begin
      rd_addr = ptr;
    end else if (cmd.outer_rd) begin
      rd_addr = i[PTR_W-1:0];
    end else begin
      rd_addr = j[PTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      mem[ptr] <= t;
    end
    rd_data <= mem[rd_addr];
  end

  // Control-side registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      budget    <= fmon_pkg::BUDGET_RESET;
      ptr       <= '0;
      fill      <= '0;
      sum       <= '0;
      frames    <= '0;
      janks     <= '0;
      drops     <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (cfg_we) begin
        budget <= cfg_wdata;
      end
      if (cmd.clear) begin
        ptr    <= '0;
        fill   <= '0;
        sum    <= '0;
        frames <= '0;
        janks  <= '0;
        drops  <= '0;
      end
      if (cmd.update) begin
        frames <= sat_add(frames, CW'(1));
        if (is_jank) begin
          janks <= sat_add(janks, CW'(1));
        end
        if (full) begin
          sum <= sum - SUM_W'(rd_data) + SUM_W'(t);
        end else begin
          sum  <= sum + SUM_W'(t);
          fill <= fill + 1'b1;
        end
        ptr <= (ptr == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr + 1'b1;
      end
      if (cmd.cap_drop && res_drop) begin
        drops <= sat_add(drops, CW'(drop_q - TW'(1)));
      end
      if (cmd.outer_cap) begin
        pend <= 1'b0;
      end else if (cmd.inner_step) begin
        pend <= (j != fill);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      t <= in_data.frame_time_us;
    end
    if (cmd.clear) begin
      res_jank     <= 1'b0;
      res_drop     <= 1'b0;
      res_drop_now <= '0;
      res_mean     <= '0;
      res_p95      <= '0;
    end
    if (cmd.update) begin
      res_jank <= is_jank;
      res_drop <= is_drop;
      res_p95  <= '0;
    end
    if (cmd.cap_drop) begin
      res_drop_now <= res_drop ? drop_q - TW'(1) : '0;
    end
    if (cmd.cap_mean) begin
      res_mean <= quo[TW-1:0];
    end
    if (cmd.cap_rank) begin
      k <= (rank_q >= fill) ? fill - 1'b1 : rank_q;
      i <= '0;
    end
    if (cmd.check_next) begin
      i <= i + 1'b1;
    end
    if (cmd.outer_cap) begin
      v      <= rd_data;
      j      <= '0;
      less   <= '0;
      lesseq <= '0;
    end else if (cmd.inner_step) begin
      if (j != fill) begin
        j <= j + 1'b1;
      end
      if (pend) begin
        if (rd_data < v) begin
          less <= less + 1'b1;
        end
        if (rd_data <= v) begin
          lesseq <= lesseq + 1'b1;
        end
      end
    end
    if (cmd.cap_p95) begin
      res_p95 <= v;
    end
    if (cmd.load_out) begin
      out_data.janked        <= res_jank;
      out_data.dropped_flag  <= res_drop;
      out_data.dropped_now   <= res_drop_now;
      out_data.frames_total  <= frames;
      out_data.jank_total    <= janks;
      out_data.dropped_total <= drops;
      out_data.mean_us       <= res_mean;
      out_data.p95_us        <= res_p95;
    end
  end

  assign stat.div_done   = div_done;
  assign stat.inner_done = (j == fill) && !pend;
  assign stat.found      = (less <= k) && (k < lesseq);
  assign stat.outer_last = ((i + 1'b1) == fill);
  assign stat.out_free   = !out_valid || !out_stall;

endmodule

// File: rtl/core/frame_time_monitor.sv
// frame_time_monitor: per-frame timing statistics over a ring window.
// A frame beat passes through two divider passes and then the rank count, which runs over the
// window fill once for each candidate up to the one that the rank search stops at.
// One beat at a time; the next is taken once the result sits in the output register.
// Synchronous active-high reset: budget 16667 us, counters and window empty, no memory sweep.
module frame_time_monitor #(
  parameter int HISTORY_DEPTH = fmon_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fmon_pkg::BUDGET_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fmon_pkg::in_beat_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fmon_pkg::out_beat_t           out_data
);

  // The controller steps through: accept, read the entry that the new frame
  // replaces, update counters and window, two passes of the shared divider
  // (drop count, window mean) while the percentile rank comes from a constant
  // multiply, then a rank-counting search over the window. The result sits in
  // an output register so the next input beat can be taken while the last
  // result waits downstream. A clear beat instead empties the counters and the window.
  fmon_pkg::ctrl_cmd_t cmd;
  fmon_pkg::dp_stat_t  stat;

  fmon_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .stat      (stat),
    .cmd       (cmd),
    .in_stall  (in_stall)
  );

  fmon_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: verif/frame_time_monitor_checker.sv
// Scoreboard for the frame time monitor: watches the budget port and both beat channels,
// predicts every result beat and compares it field by field.
// Depends on fmon_pkg for the beat structs and widths.
module frame_time_monitor_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fmon_pkg::BUDGET_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  fmon_pkg::in_beat_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  fmon_pkg::out_beat_t           out_data,
  output int                            fail_count,
  output int                            pending,
  output int                            beats_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = fmon_pkg::HISTORY_DEPTH_DEF;
  localparam int TW    = fmon_pkg::TIME_W;
  localparam int CW    = fmon_pkg::CNT_W;

  logic [fmon_pkg::BUDGET_W-1:0] budget;
  logic [CW-1:0]                 frames_cnt;
  logic [CW-1:0]                 janks_cnt;
  logic [CW-1:0]                 drops_cnt;
  logic [TW-1:0]                 ring [DEPTH];
  int                            wr_idx;
  int                            fill;
  longint unsigned               ring_sum;
  fmon_pkg::out_beat_t           stats_due [$];

  function automatic logic [CW-1:0] sat_inc(logic [CW-1:0] a, longint unsigned b);
    longint unsigned s;
    s = longint'(a) + b;
    return (s > longint'(fmon_pkg::CNT_MAX)) ? fmon_pkg::CNT_MAX : s[CW-1:0];
  endfunction

  // Advances the statistics by one input beat and returns the result it must produce.
  function automatic fmon_pkg::out_beat_t frame_stats(fmon_pkg::in_beat_t b);
    fmon_pkg::out_beat_t r;
    longint unsigned     t, bud, nd;
    int                  k;
    int unsigned         sorted [$];
    r = '0;
    t = b.frame_time_us;
    bud = (budget == 0) ? 1 : budget;
    if (b.action) begin
      frames_cnt = 0;
      janks_cnt = 0;
      drops_cnt = 0;
      wr_idx = 0;
      fill = 0;
      ring_sum = 0;
    end else begin
      frames_cnt = sat_inc(frames_cnt, 1);
      if (t > bud) begin
        r.janked = 1'b1;
        janks_cnt = sat_inc(janks_cnt, 1);
      end
      if (t > 2 * bud) begin
        r.dropped_flag = 1'b1;
        nd = t / bud - 1;
        r.dropped_now = nd[TW-1:0];
        drops_cnt = sat_inc(drops_cnt, nd);
      end
      if (fill >= DEPTH) ring_sum -= ring[wr_idx];
      else fill++;
      ring[wr_idx] = b.frame_time_us;
      ring_sum += t;
      wr_idx = (wr_idx + 1) % DEPTH;
    end
    r.frames_total = frames_cnt;
    r.jank_total = janks_cnt;
    r.dropped_total = drops_cnt;
    if (fill > 0) begin
      k = fill * 95 / 100;
      if (k >= fill) k = fill - 1;
      r.mean_us = TW'(ring_sum / longint'(fill));
      for (int i = 0; i < fill; i++) sorted = {sorted, ring[i]};
      sorted.sort();
      r.p95_us = TW'(sorted[k]);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    fmon_pkg::out_beat_t want;
    if (rst) begin
      budget <= fmon_pkg::BUDGET_RESET;
      frames_cnt = 0;
      janks_cnt = 0;
      drops_cnt = 0;
      wr_idx = 0;
      fill = 0;
      ring_sum = 0;
      stats_due.delete();
      fail_count <= 0;
      beats_checked <= 0;
      pending <= 0;
    end else begin
      // The result side goes first: a result never belongs to a beat taken at the same edge.
      if (out_valid && !out_stall) begin
        if (stats_due.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("error: result beat with nothing expected: %p", out_data);
        end else begin
          want = stats_due[0];
          stats_due.delete(0);
          beats_checked <= beats_checked + 1;
          if (out_data !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) begin
              $display("error: result %0d mismatch", beats_checked);
              $display("  expected j=%0d d=%0d dn=%0d f=%0d jt=%0d dt=%0d mean=%0d p95=%0d",
                       want.janked, want.dropped_flag, want.dropped_now, want.frames_total,
                       want.jank_total, want.dropped_total, want.mean_us, want.p95_us);
              $display("  actual   j=%0d d=%0d dn=%0d f=%0d jt=%0d dt=%0d mean=%0d p95=%0d",
                       out_data.janked, out_data.dropped_flag, out_data.dropped_now,
                       out_data.frames_total, out_data.jank_total, out_data.dropped_total,
                       out_data.mean_us, out_data.p95_us);
            end
          end
        end
      end
      if (in_valid && !in_stall) stats_due = {stats_due, frame_stats(in_data)};
      if (cfg_we) budget <= cfg_wdata;
      pending <= stats_due.size();
    end
  end
endmodule

// File: verif/frame_time_monitor_tb.sv
// Top of the frame time monitor testbench: clock, reset, budget writes and frame beats,
// plus the receiver stall pattern. Depends on fmon_pkg, frame_time_monitor and
// frame_time_monitor_checker.
module frame_time_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW = fmon_pkg::TIME_W;
  localparam int BW = fmon_pkg::BUDGET_W;
  // The slowest beats come once the window is full; the limit leaves margin over the whole run.
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam logic ACT_FRAME = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [BW-1:0]       cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  fmon_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  fmon_pkg::out_beat_t out_data;

  int fail_count;
  int pending;
  int beats_checked;
  int cycles = 0;
  int burst_left = 1;
  int holdoff_req = 0;
  int frames_sent = 0;
  int clears_sent = 0;
  logic [BW-1:0] budget_now = fmon_pkg::BUDGET_RESET;

  always #1 clk = ~clk;

  frame_time_monitor DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  frame_time_monitor_checker scoreboard (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending), .beats_checked(beats_checked)
  );

  // Watchdog: a hung block or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver stall pattern. It picks a new character for each span: never stalling,
  // light stalling and heavy stalling. A holdoff request from the stimulus makes it stall
  // for a long stretch, counted here, so the block backs up and stalls its input.
  initial begin
    int mode;
    int span;
    int holdoff_seen;
    mode = 0;
    span = 0;
    holdoff_seen = 0;
    forever begin
      @(posedge clk);
      if (holdoff_seen != holdoff_req) begin
        holdoff_seen = holdoff_req;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 2);
          span = 64;
        end
        span--;
        unique case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_stall <= ($urandom_range(0, 9) < 7);
          end
        endcase
      end
    end
  end

  // Offers one beat and returns at the edge that takes it. The sender works in bursts;
  // when a burst ends, or the caller marks the beat as the last before a pause, valid
  // drops at that same edge, and after a burst end an idle gap follows.
  task automatic send_beat(input logic act, input logic [TW-1:0] t, input bit last = 0);
    int gap;
    in_data <= '{action: act, frame_time_us: t};
    in_valid <= 1'b1;
    if (act == ACT_CLEAR) clears_sent++;
    else frames_sent++;
    // The stall is stable by the falling edge, so the next rising edge decides acceptance.
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    burst_left--;
    if (last || burst_left <= 0) begin
      in_valid <= 1'b0;
      if (!last) begin
        gap = $urandom_range(1, 6);
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
  endtask

  // Waits until every result has come back, then a little longer so that the block
  // is idle before a budget write or a new phase.
  task automatic drain;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Budget writes happen only with the block drained.
  task automatic set_budget(input logic [BW-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    budget_now = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Picks a frame duration: most often around the jank and drop thresholds of the current
  // budget, some tiny, some from a small set so the percentile sees ties, some fully random.
  function automatic logic [TW-1:0] pick_time;
    longint unsigned b, v;
    int sel;
    b = (budget_now == 0) ? 1 : budget_now;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      v = b * $urandom_range(1, 3) + $urandom_range(0, 4) - 2;
    end else if (sel < 6) begin
      v = $urandom_range(0, 40);
    end else if (sel < 8) begin
      v = 100 * $urandom_range(1, 4);
    end else begin
      v = {$urandom} & 32'hFF_FFFF;
    end
    if (v > 24'hFF_FFFF) v = 24'hFF_FFFF;
    return v[TW-1:0];
  endfunction

  // One random phase: an optional clear first, then frames with an occasional clear.
  task automatic random_phase(input int count, input int clear_odds, input bit lead_clear);
    if (lead_clear) send_beat(ACT_CLEAR, TW'($urandom));
    for (int i = 0; i < count; i++) begin
      if (clear_odds > 0 && $urandom_range(1, clear_odds) == 1)
        send_beat(ACT_CLEAR, TW'($urandom), i == count - 1);
      else
        send_beat(ACT_FRAME, pick_time(), i == count - 1);
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset budget of 16667 us: zero time, the jank and drop
    // thresholds on both sides, and the largest duration. A long receiver holdoff
    // lands here, while the sender keeps offering beats back to back.
    burst_left = 30;
    holdoff_req++;
    send_beat(ACT_FRAME, 24'd0);
    send_beat(ACT_FRAME, 24'd16667);
    send_beat(ACT_FRAME, 24'd16668);
    send_beat(ACT_FRAME, 24'd33334);
    send_beat(ACT_FRAME, 24'd33335);
    send_beat(ACT_FRAME, 24'hFF_FFFF);
    // Clear keeps the budget but empties the window; the frame after it starts afresh.
    send_beat(ACT_CLEAR, 24'hFF_FFFF);
    send_beat(ACT_FRAME, 24'd50000, 1);
    drain();

    // Smallest budget: every frame longer than one us janks, the largest drops the most.
    set_budget(20'd1);
    send_beat(ACT_FRAME, 24'd0);
    send_beat(ACT_FRAME, 24'd1);
    send_beat(ACT_FRAME, 24'd2);
    send_beat(ACT_FRAME, 24'd3);
    send_beat(ACT_FRAME, 24'hFF_FFFF, 1);
    drain();

    // A zero budget behaves as a budget of one.
    set_budget(20'd0);
    send_beat(ACT_FRAME, 24'd2);
    send_beat(ACT_FRAME, 24'd3);
    send_beat(ACT_FRAME, 24'd5, 1);
    drain();

    // A budget near the top of its range: around the budget, around twice it and at the top of the duration range.
    set_budget(20'd1_000_000);
    send_beat(ACT_FRAME, 24'd999_999);
    send_beat(ACT_FRAME, 24'd2_000_000);
    send_beat(ACT_FRAME, 24'd2_000_001);
    send_beat(ACT_FRAME, 24'hFF_FFFF, 1);
    drain();

    // Long run with no clear on top of the 13 frames already in the window: the window
    // fills and then wraps over its oldest entries.
    set_budget(BW'($urandom_range(1, 1_000_000)));
    burst_left = $urandom_range(1, 10);
    random_phase(118, 0, 0);

    // A short phase opened by a clear, with clears sprinkled in.
    set_budget(20'h5_5555);
    random_phase(8, 3, 1);

    drain();
    repeat (100) @(posedge clk);
    $display("run covered %0d frames and %0d clears, %0d results checked",
             frames_sent, clears_sent, beats_checked);
    $display("budgets from zero to the top, window filled and wrapped, input stalled");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
